/* rtl/smp_pkg.sv */
// ----------------------------------------------------------------------------
// Sponge message padder package
// Shared constants, codes, command and result types, and small helpers.
// ----------------------------------------------------------------------------
package smp_pkg;

    localparam int unsigned LANE_BITS  = 64;
    localparam int unsigned MAX_RATE   = 1600;
    localparam int unsigned BYTE_BITS  = 8;
    localparam int unsigned FIFO_DEPTH = 2;

    localparam int unsigned RATE_W     = 11;
    localparam int unsigned LPOS_W     = $clog2(LANE_BITS);
    localparam int unsigned LIDX_W     = RATE_W - LPOS_W;
    localparam int unsigned VBITS_W    = LPOS_W + 1;
    localparam int unsigned CNT_W      = 4;
    localparam int unsigned BPOS_W     = $clog2(BYTE_BITS);
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned ADDR_W     = 4;
    localparam int unsigned DATA_W     = 32;

    localparam logic [RATE_W-1:0] MAX_RATE_V = RATE_W'(MAX_RATE);
    localparam logic [RATE_W-1:0] RATE_RESET = 11'd1088;
    localparam logic [1:0]        MODE_RESET = 2'd1;
    localparam logic [7:0]        DIV_RESET  = 8'd1;

    typedef enum logic [1:0] {
        OP_BIT  = 2'd0,
        OP_BYTE = 2'd1,
        OP_PAD  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PAD_10   = 2'd0,
        PAD_101  = 2'd1,
        PAD_DIV  = 2'd2,
        PAD_BAD  = 2'd3
    } t_pad_mode;

    typedef enum logic [1:0] {
        REG_RATE = 2'd0,
        REG_MODE = 2'd1,
        REG_DIV  = 2'd2,
        REG_NONE = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_PAD    = 2'd1,
        CMD_ERROR  = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [CNT_W-1:0] cnt;
        logic [7:0]       data;
    } t_cmd;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_APPEND,
        BK_ERROR,
        BK_HEAD,
        BK_ZLAST,
        BK_TAIL,
        BK_ZBYTE,
        BK_DIV,
        BK_RATE,
        BK_ONE,
        BK_ZBLOCK
    } t_back_state;

    typedef struct packed {
        logic [LANE_BITS-1:0] lane_word;
        logic [LIDX_W-1:0]    lane_index;
        logic [VBITS_W-1:0]   valid_bits;
        logic                 block_end;
        logic                 last;
        logic                 config_error;
    } t_result;

    function automatic logic [RATE_W-1:0] eff_rate(input logic [RATE_W-1:0] r);
        logic [RATE_W-1:0] e;
        e = r;
        if (r == '0) begin
            e = RATE_W'(1);
        end else if (r > MAX_RATE_V) begin
            e = MAX_RATE_V;
        end
        return e;
    endfunction

    function automatic logic [7:0] low_mask(input logic [CNT_W-1:0] n);
        logic [8:0] m;
        if (n >= CNT_W'(BYTE_BITS)) begin
            m = 9'h1FF;
        end else begin
            m = (9'd1 << n) - 9'd1;
        end
        return m[7:0];
    endfunction

endpackage

/* rtl/smp_if.sv */
// ----------------------------------------------------------------------------
// Sponge message padder channels
// Request channel (op, data byte) and result channel (one lane per result).
// ----------------------------------------------------------------------------
interface smp_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface smp_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [smp_pkg::LANE_BITS-1:0]  lane_word;
    logic [smp_pkg::LIDX_W-1:0]     lane_index;
    logic [smp_pkg::VBITS_W-1:0]    valid_bits;
    logic                           block_end;
    logic                           last;
    logic                           config_error;

    modport source (output valid, output lane_word, output lane_index, output valid_bits,
                    output block_end, output last, output config_error, input ready);
    modport sink   (input valid, input lane_word, input lane_index, input valid_bits,
                    input block_end, input last, input config_error, output ready);
endinterface

/* rtl/smp_front.sv */
// ----------------------------------------------------------------------------
// Sponge message padder front end
// Accepts requests and classifies them into append, pad or error commands.
// ----------------------------------------------------------------------------
module smp_front (
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_op,
    input  logic [7:0]                  i_data_byte,
    input  logic [smp_pkg::RATE_W-1:0]  i_rate,
    input  logic [smp_pkg::MODE_W-1:0]  i_mode,
    input  logic                        i_full,
    output logic                        o_push,
    output smp_pkg::t_cmd               o_cmd
);

    logic bad_cfg;

    assign bad_cfg = (i_mode == smp_pkg::PAD_BAD) ||
                     ((i_mode == smp_pkg::PAD_DIV) &&
                      (i_rate[smp_pkg::BPOS_W-1:0] != '0));

    assign o_ready = !i_full;

    always_comb begin
        o_cmd.kind = smp_pkg::CMD_APPEND;
        o_cmd.cnt  = smp_pkg::CNT_W'(1);
        o_cmd.data = i_data_byte;
        o_push     = i_valid && !i_full;
        case (i_op)
            smp_pkg::OP_BIT: begin
                o_cmd.data = {7'd0, i_data_byte[0]};
            end
            smp_pkg::OP_BYTE: begin
                o_cmd.cnt = smp_pkg::CNT_W'(smp_pkg::BYTE_BITS);
            end
            smp_pkg::OP_PAD: begin
                o_cmd.kind = bad_cfg ? smp_pkg::CMD_ERROR : smp_pkg::CMD_PAD;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/smp_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// Sponge message padder command queue
// Short first-in first-out queue between front end and lane engine.
// ----------------------------------------------------------------------------
module smp_cmd_fifo #(
    parameter int unsigned DEPTH = smp_pkg::FIFO_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  smp_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output smp_pkg::t_cmd o_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    smp_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push_ok) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
        end
        if (pop_ok) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
        end
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

/* rtl/smp_back.sv */
// ----------------------------------------------------------------------------
// Sponge message padder lane engine
// Packs command bits into lanes, sequences padding, drives the result register.
// ----------------------------------------------------------------------------
module smp_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [smp_pkg::RATE_W-1:0]  i_rate,
    input  logic [smp_pkg::MODE_W-1:0]  i_mode,
    input  logic [7:0]                  i_div,
    input  logic                        i_empty,
    input  smp_pkg::t_cmd               i_cmd,
    output logic                        o_pop,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output smp_pkg::t_result            o_res
);

    localparam int unsigned RW = smp_pkg::RATE_W;
    localparam int unsigned LW = smp_pkg::LANE_BITS;
    localparam int unsigned PW = smp_pkg::LPOS_W;
    localparam int unsigned VW = smp_pkg::VBITS_W;
    localparam int unsigned CW = smp_pkg::CNT_W;

    smp_pkg::t_back_state r_state, n_state, start_state;
    logic [LW-1:0]        r_acc, n_acc;
    logic [RW-1:0]        r_bib, n_bib;
    logic [7:0]           r_dbits, n_dbits, start_dbits;
    logic [CW-1:0]        r_dcnt, n_dcnt, start_dcnt;
    logic                 r_out_valid, n_out_valid;
    smp_pkg::t_result     r_out, n_out;

    logic                 is_data;
    logic [PW-1:0]        lane_pos;
    logic [VW-1:0]        to_lane;
    logic [RW-1:0]        to_lane_w;
    logic [RW-1:0]        to_block;
    logic [RW-1:0]        rem;
    logic [RW-1:0]        step_a;
    logic [RW-1:0]        step;
    logic [RW-1:0]        new_bib;
    logic [RW-1:0]        bib_next;
    logic [RW-1:0]        k;
    logic                 hit_lane;
    logic                 hit_block;
    logic                 emit;
    logic                 can_load;
    logic                 stall;
    logic                 seg_done;
    logic                 more;
    logic                 is_last;
    logic                 item_done;
    logic [CW-1:0]        dcnt_left;
    logic [LW-1:0]        ins;
    logic [LW-1:0]        word;

    assign lane_pos  = r_bib[PW-1:0];
    assign to_lane   = VW'(LW) - {1'b0, lane_pos};
    assign to_lane_w = {{(RW-VW){1'b0}}, to_lane};
    assign to_block  = (r_bib < i_rate) ? (i_rate - r_bib) : RW'(1);
    assign is_data   = r_state inside {smp_pkg::BK_APPEND, smp_pkg::BK_HEAD, smp_pkg::BK_TAIL,
                                       smp_pkg::BK_DIV, smp_pkg::BK_RATE, smp_pkg::BK_ONE};

    always_comb begin
        case (r_state)
            smp_pkg::BK_APPEND, smp_pkg::BK_HEAD, smp_pkg::BK_TAIL,
            smp_pkg::BK_DIV, smp_pkg::BK_RATE, smp_pkg::BK_ONE: begin
                rem = {{(RW-CW){1'b0}}, r_dcnt};
            end
            smp_pkg::BK_ZBYTE: begin
                rem = (r_bib[smp_pkg::BPOS_W-1:0] == '0) ? '0 :
                      RW'(smp_pkg::BYTE_BITS) -
                      {{(RW-smp_pkg::BPOS_W){1'b0}}, r_bib[smp_pkg::BPOS_W-1:0]};
            end
            smp_pkg::BK_ZLAST: begin
                rem = ((r_bib + RW'(1)) < i_rate) ? (i_rate - r_bib - RW'(1)) : '0;
            end
            smp_pkg::BK_ZBLOCK: begin
                rem = (r_bib == '0) ? '0 : to_block;
            end
            default: begin
                rem = '0;
            end
        endcase
    end

    assign step_a    = (rem < to_lane_w) ? rem : to_lane_w;
    assign step      = (step_a < to_block) ? step_a : to_block;
    assign new_bib   = r_bib + step;
    assign hit_lane  = (step != '0) && (step == to_lane_w);
    assign hit_block = (step != '0) && (step == to_block);
    assign emit      = hit_lane || hit_block;
    assign k         = new_bib - RW'(1);
    assign bib_next  = hit_block ? '0 : new_bib;
    assign dcnt_left = r_dcnt - step[CW-1:0];
    assign seg_done  = (rem == step);
    assign ins       = is_data ?
                       ({{(LW-8){1'b0}}, r_dbits & smp_pkg::low_mask(step[CW-1:0])} << lane_pos) :
                       '0;
    assign word      = r_acc | ins;
    assign more      = (dcnt_left != '0) &&
                       ({{(RW-CW){1'b0}}, dcnt_left} >= (i_rate - bib_next));
    assign can_load  = !r_out_valid || i_res_ready;
    assign stall     = (emit || (r_state == smp_pkg::BK_ERROR)) && !can_load;

    always_comb begin
        case (r_state)
            smp_pkg::BK_APPEND:  is_last = !more;
            smp_pkg::BK_HEAD:    is_last = (i_mode == smp_pkg::PAD_10) && hit_block;
            smp_pkg::BK_TAIL,
            smp_pkg::BK_ONE,
            smp_pkg::BK_ZBLOCK:  is_last = hit_block;
            default:             is_last = 1'b0;
        endcase
    end

    always_comb begin
        start_dbits = 8'd1;
        start_dcnt  = CW'(1);
        case (i_cmd.kind)
            smp_pkg::CMD_APPEND: begin
                start_state = smp_pkg::BK_APPEND;
                start_dbits = i_cmd.data;
                start_dcnt  = i_cmd.cnt;
            end
            smp_pkg::CMD_PAD:   start_state = smp_pkg::BK_HEAD;
            smp_pkg::CMD_ERROR: start_state = smp_pkg::BK_ERROR;
            default:            start_state = smp_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_bib       = r_bib;
        n_dbits     = r_dbits;
        n_dcnt      = r_dcnt;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        item_done   = 1'b0;
        if (!stall) begin
            if (emit) begin
                n_out_valid        = 1'b1;
                n_out.lane_word    = word;
                n_out.lane_index   = k[RW-1:PW];
                n_out.valid_bits   = {1'b0, k[PW-1:0]} + VW'(1);
                n_out.block_end    = hit_block;
                n_out.last         = is_last;
                n_out.config_error = 1'b0;
                n_acc              = '0;
            end else begin
                n_acc = word;
            end
            n_bib   = bib_next;
            n_dbits = r_dbits >> step[CW-1:0];
            n_dcnt  = dcnt_left;
            case (r_state)
                smp_pkg::BK_IDLE: begin
                    item_done = 1'b1;
                end
                smp_pkg::BK_ERROR: begin
                    n_out_valid        = 1'b1;
                    n_out.lane_word    = '0;
                    n_out.lane_index   = '0;
                    n_out.valid_bits   = '0;
                    n_out.block_end    = 1'b0;
                    n_out.last         = 1'b1;
                    n_out.config_error = 1'b1;
                    item_done          = 1'b1;
                end
                smp_pkg::BK_APPEND, smp_pkg::BK_TAIL, smp_pkg::BK_ZBLOCK: begin
                    item_done = seg_done;
                end
                smp_pkg::BK_HEAD: begin
                    if (seg_done) begin
                        case (i_mode)
                            smp_pkg::PAD_10:  n_state = smp_pkg::BK_ZBLOCK;
                            smp_pkg::PAD_101: n_state = smp_pkg::BK_ZLAST;
                            default:          n_state = smp_pkg::BK_ZBYTE;
                        endcase
                    end
                end
                smp_pkg::BK_ZLAST: begin
                    if (seg_done) begin
                        n_state = smp_pkg::BK_TAIL;
                        n_dbits = 8'd1;
                        n_dcnt  = CW'(1);
                    end
                end
                smp_pkg::BK_ZBYTE: begin
                    if (seg_done) begin
                        n_state = smp_pkg::BK_DIV;
                        n_dbits = i_div;
                        n_dcnt  = CW'(smp_pkg::BYTE_BITS);
                    end
                end
                smp_pkg::BK_DIV: begin
                    if (seg_done) begin
                        n_state = smp_pkg::BK_RATE;
                        n_dbits = i_rate[smp_pkg::BPOS_W +: 8];
                        n_dcnt  = CW'(smp_pkg::BYTE_BITS);
                    end
                end
                smp_pkg::BK_RATE: begin
                    if (seg_done) begin
                        n_state = smp_pkg::BK_ONE;
                        n_dbits = 8'd1;
                        n_dcnt  = CW'(1);
                    end
                end
                smp_pkg::BK_ONE: begin
                    if (seg_done) begin
                        n_state = smp_pkg::BK_ZBLOCK;
                    end
                end
                default: begin
                    n_state = smp_pkg::BK_IDLE;
                end
            endcase
            if (item_done) begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = start_state;
                    n_dbits = start_dbits;
                    n_dcnt  = start_dcnt;
                end else begin
                    n_state = smp_pkg::BK_IDLE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smp_pkg::BK_IDLE;
            r_acc       <= '0;
            r_bib       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_bib       <= n_bib;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dbits <= n_dbits;
        r_dcnt  <= n_dcnt;
        r_out   <= n_out;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

/* rtl/sponge_message_padder_core.sv */
// ----------------------------------------------------------------------------
// Sponge message padder core
// Packs message bits into sponge blocks and emits 64-bit lanes with padding.
// ----------------------------------------------------------------------------
// Request channel i_req: op 0 appends data_byte[0], op 1 appends data_byte
// LSB first, op 2 pads and ends the message, op 3 is dropped. Result channel
// o_rsp carries one lane per result; last marks the final result of a request.
// Registers on the APB port: rate_bits at 0x0, padding_mode at 0x4 and
// diversifier at 0x8; write them only while the block is idle.
// A request passes the command queue and the lane engine state before the
// result register drives it on o_rsp. A byte append is split at each lane it
// closes before its last bit. Padding runs through head, zero, diversifier,
// rate and one-bit segments as the mode selects, in the single lane packing
// unit, which inserts up to one byte or one lane run of zeros per cycle unless stalled.
// Reset clears the lane accumulator, block position, command queue and result
// register, and loads the register reset values. When the receiver stalls, the
// result is held, the lane engine stops before its next result, and
// i_req.ready drops once the command queue fills.
// ----------------------------------------------------------------------------
module sponge_message_padder_core #(
    parameter int unsigned FIFO_DEPTH = smp_pkg::FIFO_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    smp_req_if.sink                         i_req,
    smp_rsp_if.source                       o_rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [smp_pkg::ADDR_W-1:0]      paddr,
    input  logic [smp_pkg::DATA_W-1:0]      pwdata,
    output logic [smp_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);

    logic [smp_pkg::RATE_W-1:0] r_rate;
    logic [smp_pkg::MODE_W-1:0] r_mode;
    logic [7:0]                 r_div;
    logic [smp_pkg::RATE_W-1:0] eff;
    logic                       wr_en;
    logic [1:0]                 reg_sel;

    smp_pkg::t_cmd              push_cmd;
    smp_pkg::t_cmd              head_cmd;
    logic                       push;
    logic                       full;
    logic                       empty;
    logic                       pop;
    smp_pkg::t_result           res;
    logic                       res_valid;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];
    assign eff     = smp_pkg::eff_rate(r_rate);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= smp_pkg::RATE_RESET;
            r_mode <= smp_pkg::MODE_RESET;
            r_div  <= smp_pkg::DIV_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                smp_pkg::REG_RATE: r_rate <= pwdata[smp_pkg::RATE_W-1:0];
                smp_pkg::REG_MODE: r_mode <= pwdata[smp_pkg::MODE_W-1:0];
                smp_pkg::REG_DIV:  r_div  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            smp_pkg::REG_RATE: prdata = {{(smp_pkg::DATA_W-smp_pkg::RATE_W){1'b0}}, r_rate};
            smp_pkg::REG_MODE: prdata = {{(smp_pkg::DATA_W-smp_pkg::MODE_W){1'b0}}, r_mode};
            smp_pkg::REG_DIV:  prdata = {{(smp_pkg::DATA_W-8){1'b0}}, r_div};
            default:           prdata = '0;
        endcase
    end

    smp_front u_front (
        .i_valid     (i_req.valid),
        .o_ready     (i_req.ready),
        .i_op        (i_req.op),
        .i_data_byte (i_req.data_byte),
        .i_rate      (eff),
        .i_mode      (r_mode),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    smp_cmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    smp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rate      (eff),
        .i_mode      (r_mode),
        .i_div       (r_div),
        .i_empty     (empty),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_res_valid (res_valid),
        .i_res_ready (o_rsp.ready),
        .o_res       (res)
    );

    assign o_rsp.valid        = res_valid;
    assign o_rsp.lane_word    = res.lane_word;
    assign o_rsp.lane_index   = res.lane_index;
    assign o_rsp.valid_bits   = res.valid_bits;
    assign o_rsp.block_end    = res.block_end;
    assign o_rsp.last         = res.last;
    assign o_rsp.config_error = res.config_error;

endmodule

/* rtl/smp_checker.sv */
// ----------------------------------------------------------------------------
// Sponge message padder checker
// Port-level properties of the result channel, bound to the core.
// ----------------------------------------------------------------------------
module smp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           i_ready,
    input logic [smp_pkg::LANE_BITS-1:0]  i_lane_word,
    input logic [smp_pkg::LIDX_W-1:0]     i_lane_index,
    input logic [smp_pkg::VBITS_W-1:0]    i_valid_bits,
    input logic                           i_block_end,
    input logic                           i_last,
    input logic                           i_config_error
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_lane_word) &&
        $stable(i_valid_bits) && $stable(i_last) && $stable(i_block_end))
        else $error("stalled result changed");

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_config_error |-> i_last && (i_lane_word == '0) &&
        (i_valid_bits == '0) && (i_lane_index == '0) && !i_block_end)
        else $error("malformed error result");

    a_lane_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_config_error |-> (i_valid_bits != '0) &&
        (i_valid_bits <= smp_pkg::VBITS_W'(smp_pkg::LANE_BITS)) &&
        (i_block_end || (i_valid_bits == smp_pkg::VBITS_W'(smp_pkg::LANE_BITS))))
        else $error("partial lane without block end");

endmodule

bind sponge_message_padder_core smp_checker u_smp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_rsp.valid),
    .i_ready        (o_rsp.ready),
    .i_lane_word    (o_rsp.lane_word),
    .i_lane_index   (o_rsp.lane_index),
    .i_valid_bits   (o_rsp.valid_bits),
    .i_block_end    (o_rsp.block_end),
    .i_last         (o_rsp.last),
    .i_config_error (o_rsp.config_error)
);
